// ===== hdl/bee_pkg.sv =====
// Shared types, character codes and helpers for the Boolean expression evaluator.
`timescale 1ns / 1ps

package bee_pkg;

    // Open-level count is kept at full 32-bit range and saturates there
    localparam int DEPTH_W = 32;
    localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;

    // Character codes
    localparam logic [7:0] CH_AND   = 8'h26;
    localparam logic [7:0] CH_OR    = 8'h7C;
    localparam logic [7:0] CH_NAND  = 8'h40;
    localparam logic [7:0] CH_XOR   = 8'h24;
    localparam logic [7:0] CH_NOT   = 8'h21;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_TRUE  = 8'h54;
    localparam logic [7:0] CH_FALSE = 8'h46;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Operator codes
    localparam logic [1:0] OP_AND  = 2'd0;
    localparam logic [1:0] OP_OR   = 2'd1;
    localparam logic [1:0] OP_NAND = 2'd2;
    localparam logic [1:0] OP_XOR  = 2'd3;

    // Result status codes, lowest wins
    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_CHAR    = 3'd1;
    localparam logic [2:0] STATUS_EXTRA   = 3'd2;
    localparam logic [2:0] STATUS_MISSING = 3'd3;
    localparam logic [2:0] STATUS_SEQ     = 3'd4;
    localparam logic [2:0] STATUS_DEEP    = 3'd5;

    // Evaluation context of one nesting level
    typedef struct packed {
        logic       negate;
        logic       have;
        logic [1:0] op;
        logic       acc;
    } level_t;

    typedef struct packed {
        logic   push;
        level_t data;
    } push_req_t;

    function automatic logic apply_op(logic [1:0] op, logic a, logic b);
        logic r;
        case (op)
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_NAND: r = ~(a & b);
            default: r = a ^ b;
        endcase
        return r;
    endfunction

    // Fold an operand into a level, honouring a waiting negation
    function automatic level_t take_value(level_t lv, logic v);
        logic   x;
        level_t r;
        x        = v ^ lv.negate;
        r        = lv;
        r.negate = 1'b0;
        r.acc    = lv.have ? apply_op(lv.op, lv.acc, x) : x;
        r.have   = 1'b1;
        return r;
    endfunction

endpackage

// ===== hdl/boolean_expression_evaluator_unit.sv =====
// Top level of the Boolean expression evaluator.
`timescale 1ns / 1ps
// Evaluates a Boolean expression streamed in one ASCII character per request
// on the s_ channel; s_tlast marks the final character. Values are T and F,
// operators & | @ (NAND) $ (XOR) fold left to right, a prefix ! negates the
// next value or group, parentheses nest and spaces are skipped.
// Only the request carrying s_tlast produces a result on the m_ channel:
// m_tdata[0] is the value, m_tdata[3:1] the status (0 ok, 1 bad character,
// 2 extra ')', 3 missing ')', 4 bad sequence, 5 too deep).
// Throughput: one character per cycle unless stalled. Latency: the result is
// registered and presented the cycle after the last character is accepted.
// Each character is decoded and folded in a single pass between the state
// registers; the saved-level stack is a memory whose top entry is kept
// prefetched in a register, so a ')' pops without a wait.
// When the receiver stalls, the pending result is held and s_tready stays
// low until it is taken. Reset (aresetn low) drops any result, clears the
// evaluation state and opens a fresh expression; no clearing pass is needed.
module boolean_expression_evaluator_unit #(
    parameter int MAX_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] value, [3:1] status, [7:4] zero
);

    localparam int ERR_CHAR  = 0;
    localparam int ERR_EXTRA = 1;
    localparam int ERR_SEQ   = 2;
    localparam int ERR_DEEP  = 3;

    localparam logic [bee_pkg::DEPTH_W-1:0] MAX_D = bee_pkg::DEPTH_W'(MAX_DEPTH);

    logic [bee_pkg::DEPTH_W-1:0] depth_reg, depth_next, depth_step, depth_dec;
    bee_pkg::level_t             lvl_reg, lvl_next, lvl_step;
    logic                        expect_reg, expect_next, expect_step;
    logic [3:0]                  err_reg, err_next, err_step;
    logic                        m_valid_reg, m_valid_next;
    logic                        m_value_reg, m_value_next;
    logic [2:0]                  m_status_reg, m_status_next;
    logic [2:0]                  status;

    bee_pkg::push_req_t push_req;
    bee_pkg::push_req_t stack_req;
    bee_pkg::level_t    top;
    bee_pkg::level_t    restored;
    logic               in_fire;

    assign s_tready = ~m_valid_reg | m_tready;
    assign in_fire  = s_tvalid & s_tready;
    assign depth_dec = depth_reg - bee_pkg::DEPTH_W'(1);

    // Effect of one character on the evaluation state
    always_comb begin
        depth_step    = depth_reg;
        lvl_step      = lvl_reg;
        expect_step   = expect_reg;
        err_step      = err_reg;
        push_req.push = 1'b0;
        push_req.data = lvl_reg;
        restored      = top;
        case (s_tdata)
            bee_pkg::CH_SPACE: begin
            end
            bee_pkg::CH_TRUE, bee_pkg::CH_FALSE: begin
                if (!expect_reg) begin
                    err_step[ERR_SEQ] = 1'b1;
                end
                lvl_step    = bee_pkg::take_value(lvl_reg, s_tdata == bee_pkg::CH_TRUE);
                expect_step = 1'b0;
            end
            bee_pkg::CH_NOT: begin
                if (!expect_reg || lvl_reg.negate) begin
                    err_step[ERR_SEQ] = 1'b1;
                end
                lvl_step.negate = 1'b1;
            end
            bee_pkg::CH_OPEN: begin
                if (!expect_reg) begin
                    err_step[ERR_SEQ] = 1'b1;
                end
                if (depth_reg < MAX_D) begin
                    push_req.push = 1'b1;
                end else begin
                    err_step[ERR_DEEP] = 1'b1;
                end
                if (depth_reg != bee_pkg::DEPTH_SAT) begin
                    depth_step = depth_reg + bee_pkg::DEPTH_W'(1);
                end
                lvl_step    = '0;
                expect_step = 1'b1;
            end
            bee_pkg::CH_CLOSE: begin
                if (depth_reg == '0) begin
                    err_step[ERR_EXTRA] = 1'b1;
                end else begin
                    if (expect_reg) begin
                        err_step[ERR_SEQ] = 1'b1;
                    end
                    depth_step  = depth_dec;
                    expect_step = 1'b0;
                    // Unsaved levels only drop the count
                    if (depth_dec < MAX_D) begin
                        lvl_step = bee_pkg::take_value(restored, lvl_reg.acc);
                    end
                end
            end
            bee_pkg::CH_AND, bee_pkg::CH_OR, bee_pkg::CH_NAND, bee_pkg::CH_XOR: begin
                if (expect_reg) begin
                    err_step[ERR_SEQ] = 1'b1;
                end
                case (s_tdata)
                    bee_pkg::CH_AND:  lvl_step.op = bee_pkg::OP_AND;
                    bee_pkg::CH_OR:   lvl_step.op = bee_pkg::OP_OR;
                    bee_pkg::CH_NAND: lvl_step.op = bee_pkg::OP_NAND;
                    default:          lvl_step.op = bee_pkg::OP_XOR;
                endcase
                expect_step = 1'b1;
            end
            default: begin
                err_step[ERR_CHAR] = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (err_step[ERR_CHAR]) begin
            status = bee_pkg::STATUS_CHAR;
        end else if (err_step[ERR_EXTRA]) begin
            status = bee_pkg::STATUS_EXTRA;
        end else if (depth_step != '0) begin
            status = bee_pkg::STATUS_MISSING;
        end else if (err_step[ERR_SEQ] || expect_step) begin
            status = bee_pkg::STATUS_SEQ;
        end else if (err_step[ERR_DEEP]) begin
            status = bee_pkg::STATUS_DEEP;
        end else begin
            status = bee_pkg::STATUS_OK;
        end
    end

    always_comb begin
        depth_next    = depth_reg;
        lvl_next      = lvl_reg;
        expect_next   = expect_reg;
        err_next      = err_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        if (in_fire) begin
            if (s_tlast) begin
                // Emit and open a fresh expression
                depth_next    = '0;
                lvl_next      = '0;
                expect_next   = 1'b1;
                err_next      = '0;
                m_valid_next  = 1'b1;
                m_status_next = status;
                m_value_next  = (status == bee_pkg::STATUS_OK) ? lvl_step.acc : 1'b0;
            end else begin
                depth_next  = depth_step;
                lvl_next    = lvl_step;
                expect_next = expect_step;
                err_next    = err_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            lvl_reg     <= '0;
            expect_reg  <= 1'b1;
            err_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            depth_reg   <= depth_next;
            lvl_reg     <= lvl_next;
            expect_reg  <= expect_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    // Push only on an accepted request
    assign stack_req = {push_req.push & in_fire, push_req.data};

    bee_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .aclk       (aclk),
        .push_req   (stack_req),
        .depth      (depth_reg),
        .depth_next (depth_next),
        .top        (top)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_status_reg, m_value_reg};

endmodule

// ===== hdl/bee_stack.sv =====
// Saved-level stack with a registered top-of-stack read.
`timescale 1ns / 1ps

module bee_stack #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                         aclk,
    input  bee_pkg::push_req_t           push_req,
    input  logic [bee_pkg::DEPTH_W-1:0]  depth,
    input  logic [bee_pkg::DEPTH_W-1:0]  depth_next,
    output bee_pkg::level_t              top
);

    localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    bee_pkg::level_t mem [MAX_DEPTH];
    bee_pkg::level_t top_reg;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign wr_addr = ADDR_W'(depth);
    // Prefetch the entry that will sit on top after this cycle
    assign rd_addr = ADDR_W'(depth_next - bee_pkg::DEPTH_W'(1));

    always_ff @(posedge aclk) begin
        if (push_req.push) begin
            mem[wr_addr] <= push_req.data;
        end
    end

    // Forward a fresh push, otherwise read the new top
    always_ff @(posedge aclk) begin
        if (push_req.push) begin
            top_reg <= push_req.data;
        end else begin
            top_reg <= mem[rd_addr];
        end
    end

    assign top = top_reg;

endmodule

// ===== hdl/bee_checker.sv =====
// Port-level checks for the Boolean expression evaluator, bound to the top level.
`timescale 1ns / 1ps

module bee_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A result only follows the final character of an expression
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a closing character");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:4] == 4'b0000 && m_tdata[3:1] <= bee_pkg::STATUS_DEEP)
        else $error("status code out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:1] != bee_pkg::STATUS_OK |-> !m_tdata[0])
        else $error("value set on a failed expression");

endmodule

bind boolean_expression_evaluator_unit bee_checker u_bee_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
